// ----- rtl/ngh_pkg.sv -----
package ngh_pkg;

  // Sample, gain and level width (Q1.23 / Q0.23)
  localparam int unsigned DataW = 24;
  // Widest operand of the shared multiplier (up_factor, Q10.22)
  localparam int unsigned FactW = 32;
  localparam int unsigned ProdW = DataW + FactW;
  localparam int unsigned DownW = 25;
  localparam int unsigned HoldW = 16;
  localparam int unsigned AddrW = 5;
  localparam int unsigned ApbW  = 32;

  localparam logic [DataW-1:0] UnityGain = 24'h800000;
  localparam logic [DataW-1:0] PosMax    = 24'h7FFFFF;

  // Register indexes (byte address 4*index)
  localparam logic [2:0] RegOpenLevel   = 3'd0;
  localparam logic [2:0] RegCloseLevel  = 3'd1;
  localparam logic [2:0] RegFloorGain   = 3'd2;
  localparam logic [2:0] RegUpFactor    = 3'd3;
  localparam logic [2:0] RegDownFactor  = 3'd4;
  localparam logic [2:0] RegHoldSamples = 3'd5;

  // Register reset values
  localparam logic [DataW-1:0] OpenLevelRst   = 24'd265;
  localparam logic [DataW-1:0] CloseLevelRst  = 24'd133;
  localparam logic [DataW-1:0] FloorGainRst   = 24'd8389;
  localparam logic [FactW-1:0] UpFactorRst    = 32'd4843495;
  localparam logic [DownW-1:0] DownFactorRst  = 25'd16769901;
  localparam logic [HoldW-1:0] HoldSamplesRst = 16'd4800;

  typedef enum logic [2:0] {
    S_IDLE,  // wait for a sample, update gate and hold
    S_GMUL,  // gain times attack or release factor
    S_GUPD,  // clamp the new gain at its target
    S_OMUL,  // sample magnitude times new gain
    S_OUT    // round, saturate, hand to output register
  } ngh_state_e;

endpackage

// ----- rtl/ngh_mul.sv -----
module ngh_mul (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [ngh_pkg::DataW-1:0]   a_i,
  input  logic [ngh_pkg::FactW-1:0]   b_i,
  output logic [ngh_pkg::ProdW-1:0]   p_o
);

  logic [ngh_pkg::ProdW-1:0] prod_q;

  // Registered unsigned product; hold while idle
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= a_i * b_i;
    end
  end

  assign p_o = prod_q;

endmodule

// ----- rtl/noise_gate_hold_ramp.sv -----
// Channel     | Direction | Handshake                   | Contents
// ------------+-----------+-----------------------------+---------------------------------
// s_axis      | in        | tvalid/tready               | tdata[23:0] sample_in
// m_axis      | out       | tvalid/tready               | tdata[23:0] gated_sample,
//             |           |                             | tdata[47:24] current_gain,
//             |           |                             | tuser gate_open
// apb         | in        | psel/penable, pready tied 1 | six registers at 4*index
//
// Each sample runs through the transfer step (gate and hold update), then two
// passes through the single 24x32 registered multiplier, first for the gain
// ramp and then for the output product, each followed by a clamp step.
// s_axis_tready is high only while the sequencer idles; the output register
// lets a new sample enter while the previous result is still waiting.
// A stalled m_axis holds the sequencer in its last step until the output frees.
// rst_ni resets gate state, gain and registers at once; no clearing pass.
module noise_gate_hold_ramp (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [23:0] sample_in
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [23:0] gated_sample, [47:24] current_gain
  output logic        m_axis_tuser,   // [0] gate_open
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned DW = ngh_pkg::DataW;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [DW-1:0]                  open_lvl_q, close_lvl_q, floor_q;
  logic [ngh_pkg::FactW-1:0]      up_q;
  logic [ngh_pkg::DownW-1:0]      down_q;
  logic [ngh_pkg::HoldW-1:0]      hold_len_q;
  logic                           cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Decode on the word index; byte offsets are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_lvl_q  <= ngh_pkg::OpenLevelRst;
      close_lvl_q <= ngh_pkg::CloseLevelRst;
      floor_q     <= ngh_pkg::FloorGainRst;
      up_q        <= ngh_pkg::UpFactorRst;
      down_q      <= ngh_pkg::DownFactorRst;
      hold_len_q  <= ngh_pkg::HoldSamplesRst;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        ngh_pkg::RegOpenLevel:   open_lvl_q  <= pwdata[DW-1:0];
        ngh_pkg::RegCloseLevel:  close_lvl_q <= pwdata[DW-1:0];
        ngh_pkg::RegFloorGain:   floor_q     <= pwdata[DW-1:0];
        ngh_pkg::RegUpFactor:    up_q        <= pwdata[ngh_pkg::FactW-1:0];
        ngh_pkg::RegDownFactor:  down_q      <= pwdata[ngh_pkg::DownW-1:0];
        ngh_pkg::RegHoldSamples: hold_len_q  <= pwdata[ngh_pkg::HoldW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      ngh_pkg::RegOpenLevel:   prdata = {8'd0, open_lvl_q};
      ngh_pkg::RegCloseLevel:  prdata = {8'd0, close_lvl_q};
      ngh_pkg::RegFloorGain:   prdata = {8'd0, floor_q};
      ngh_pkg::RegUpFactor:    prdata = up_q;
      ngh_pkg::RegDownFactor:  prdata = {7'd0, down_q};
      ngh_pkg::RegHoldSamples: prdata = {16'd0, hold_len_q};
      default:                 prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer and datapath state
  // ---------------------------------------------------------------------------
  ngh_pkg::ngh_state_e state_q, state_d;

  logic                        open_q, open_d;
  logic [ngh_pkg::HoldW-1:0]   hold_q, hold_d;
  logic [DW-1:0]               gain_q, gain_d;
  logic                        rise_q, rise_d;   // gain moves up toward target
  logic [DW-1:0]               mag_q;
  logic                        neg_q;

  logic                        m_valid_q, m_valid_d;
  logic [47:0]                 m_data_q, m_data_d;
  logic                        m_user_q, m_user_d;

  logic                        in_xfer;
  logic [DW-1:0]               mag_w;
  logic                        pass_w;
  logic [DW-1:0]               target_w;

  // shared multiplier
  logic                        mul_en;
  logic [DW-1:0]               mul_a;
  logic [ngh_pkg::FactW-1:0]   mul_b;
  logic [ngh_pkg::ProdW-1:0]   prod;

  // gain clamp and output rounding
  logic [33:0]                 g_up;
  logic [31:0]                 g_dn;
  logic [48:0]                 neg_sum;
  logic [25:0]                 q_neg;
  logic [24:0]                 q_pos;
  logic [DW-1:0]               q_neg_sat;
  logic [DW-1:0]               out_w;

  assign s_axis_tready = (state_q == ngh_pkg::S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // Magnitude; the most negative sample maps to unity
  assign mag_w  = s_axis_tdata[23] ? (24'd0 - s_axis_tdata) : s_axis_tdata;
  // Hysteresis: close level keeps an open gate, open level opens a closed one
  assign pass_w = (mag_w >= close_lvl_q) && (open_q || (mag_w >= open_lvl_q));

  assign target_w = open_q ? ngh_pkg::UnityGain : floor_q;

  // Gain pass uses the ramp factor, output pass uses the new gain
  assign mul_en = (state_q == ngh_pkg::S_GMUL) || (state_q == ngh_pkg::S_OMUL);
  assign mul_a  = (state_q == ngh_pkg::S_OMUL) ? mag_q : gain_q;
  assign mul_b  = (state_q == ngh_pkg::S_OMUL) ? {8'd0, gain_q}
                : (rise_q ? up_q : {7'd0, down_q});

  ngh_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign g_up = prod[55:22];   // Q10.22 factor
  assign g_dn = prod[55:24];   // Q1.24 factor

  // Negative products round toward minus infinity: add all-ones below bit 23
  assign neg_sum   = {1'b0, prod[47:0]} + 49'h7FFFFF;
  assign q_neg     = neg_sum[48:23];
  assign q_neg_sat = (q_neg > 26'd8388608) ? ngh_pkg::UnityGain : q_neg[DW-1:0];
  assign q_pos     = prod[47:23];
  assign out_w     = neg_q ? (24'd0 - q_neg_sat)
                   : ((q_pos > {1'b0, ngh_pkg::PosMax}) ? ngh_pkg::PosMax : q_pos[DW-1:0]);

  always_comb begin
    state_d   = state_q;
    open_d    = open_q;
    hold_d    = hold_q;
    gain_d    = gain_q;
    rise_d    = rise_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;

    // Drop the result once it is taken
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      ngh_pkg::S_IDLE: begin
        if (in_xfer) begin
          if (pass_w) begin
            open_d = 1'b1;
            hold_d = hold_len_q;
          end else if (open_q) begin
            if (hold_q <= 16'd1) begin
              open_d = 1'b0;
              hold_d = '0;
            end else begin
              hold_d = hold_q - 16'd1;
            end
          end
          // Both compares in parallel, pick by the new gate state
          rise_d  = open_d ? (gain_q < ngh_pkg::UnityGain) : (gain_q < floor_q);
          state_d = ngh_pkg::S_GMUL;
        end
      end
      ngh_pkg::S_GMUL: begin
        state_d = ngh_pkg::S_GUPD;
      end
      ngh_pkg::S_GUPD: begin
        // Clamp at the target, then keep 24 bits
        if (rise_q) begin
          gain_d = (g_up > {10'd0, target_w}) ? target_w : g_up[DW-1:0];
        end else begin
          gain_d = (g_dn < {8'd0, target_w}) ? target_w : g_dn[DW-1:0];
        end
        state_d = ngh_pkg::S_OMUL;
      end
      ngh_pkg::S_OMUL: begin
        state_d = ngh_pkg::S_OUT;
      end
      ngh_pkg::S_OUT: begin
        // Hold here while the output register is still full
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {gain_q, out_w};
          m_user_d  = open_q;
          state_d   = ngh_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = ngh_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ngh_pkg::S_IDLE;
      open_q    <= 1'b0;
      hold_q    <= '0;
      gain_q    <= ngh_pkg::FloorGainRst;
      rise_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      open_q    <= open_d;
      hold_q    <= hold_d;
      gain_q    <= gain_d;
      rise_q    <= rise_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      mag_q <= mag_w;
      neg_q <= s_axis_tdata[23];
    end
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_hold_zero_when_closed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !open_q |-> (hold_q == '0))
    else $error("hold count left nonzero while gate closed");

  a_out_from_last_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ngh_pkg::S_OUT))
    else $error("result loaded outside the final step");

  a_stall_holds_seq : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ngh_pkg::S_OUT) && m_axis_tvalid && !m_axis_tready
      |=> (state_q == ngh_pkg::S_OUT))
    else $error("sequencer left final step while output register full");

  a_xfer_starts_seq : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> (state_q == ngh_pkg::S_GMUL))
    else $error("accepted sample did not start the gain pass");

endmodule

// ----- bench/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Byte addresses 24 and 28 decode to no register; writes there must be dropped.
  localparam logic [2:0] RegSpare = 3'd7;

  // Cycles without any transfer on either stream before the run is declared hung.
  localparam int unsigned StallLimit = 4000;
  // Cycles to let the five-step sequencer settle before touching registers.
  localparam int unsigned SettleCycles = 8;

  // One result transfer: gated sample, gate state, gain applied.
  typedef struct packed {
    logic [23:0] gated;
    logic        open;
    logic [23:0] gain;
  } gate_result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;   // [23:0] sample_in
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;         // [23:0] gated_sample, [47:24] current_gain
  logic        m_axis_tuser;         // [0] gate_open
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [4:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  // Shadow copy of the register file, masked to the register widths.
  logic [23:0] cfg_open_level   = ngh_pkg::OpenLevelRst;
  logic [23:0] cfg_close_level  = ngh_pkg::CloseLevelRst;
  logic [23:0] cfg_floor_gain   = ngh_pkg::FloorGainRst;
  logic [31:0] cfg_up_factor    = ngh_pkg::UpFactorRst;
  logic [24:0] cfg_down_factor  = ngh_pkg::DownFactorRst;
  logic [15:0] cfg_hold_samples = ngh_pkg::HoldSamplesRst;

  // Shadow copy of the gate state.
  logic        gate_is_open = 1'b0;
  logic [15:0] hold_count   = '0;
  logic [23:0] gain_level   = ngh_pkg::FloorGainRst;

  gate_result_t gated_queue[$];
  gate_result_t head_result;
  int unsigned  fail_count  = 0;
  int unsigned  quiet_count = 0;
  // Set to run both streams with no random idles or stalls from the bench.
  bit           steady_flow = 1'b0;

  noise_gate_hold_ramp DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Gate predictor: advance the shadow state by one sample and return the
  // result the block must emit for it.
  // ---------------------------------------------------------------------------
  function automatic gate_result_t step_gate(input logic [23:0] sample);
    logic [24:0]  mag;
    logic [23:0]  target;
    logic [63:0]  ramp;
    logic [63:0]  prod;
    logic [63:0]  quot;
    gate_result_t res;
    // Magnitude; the most negative sample gives exactly unity.
    mag = sample[23] ? (25'h1000000 - {1'b0, sample}) : {1'b0, sample};

    // Level above close keeps an open gate open; a closed one also needs open.
    if (mag >= {1'b0, cfg_close_level} &&
        (gate_is_open || mag >= {1'b0, cfg_open_level})) begin
      gate_is_open = 1'b1;
      hold_count   = cfg_hold_samples;
    end else if (gate_is_open) begin
      // Close when the count runs out; never wrap below zero.
      if (hold_count <= 16'd1) begin
        hold_count   = '0;
        gate_is_open = 1'b0;
      end else begin
        hold_count = hold_count - 16'd1;
      end
    end

    // Ramp toward unity or the floor, clamped at the target.
    target = gate_is_open ? ngh_pkg::UnityGain : cfg_floor_gain;
    if (gain_level < target) begin
      ramp = ({40'd0, gain_level} * {32'd0, cfg_up_factor}) >> 22;
      if (ramp > {40'd0, target}) ramp = {40'd0, target};
    end else begin
      ramp = ({40'd0, gain_level} * {39'd0, cfg_down_factor}) >> 24;
      if (ramp < {40'd0, target}) ramp = {40'd0, target};
    end
    gain_level = ramp[23:0];

    // Output product, floored and saturated to the signed 24-bit range.
    prod = {39'd0, mag} * {40'd0, gain_level};
    if (sample[23]) begin
      quot = (prod + 64'h7FFFFF) >> 23;
      if (quot > 64'h800000) quot = 64'h800000;
      res.gated = 24'd0 - quot[23:0];
    end else begin
      quot = prod >> 23;
      if (quot > {40'd0, ngh_pkg::PosMax}) quot = {40'd0, ngh_pkg::PosMax};
      res.gated = quot[23:0];
    end
    res.open = gate_is_open;
    res.gain = gain_level;
    return res;
  endfunction

  // Random sample with magnitude in [lo, hi] and random sign.
  function automatic logic [23:0] make_sample(input int unsigned lo, input int unsigned hi);
    int unsigned mag;
    mag = $urandom_range(hi, lo);
    if ($urandom_range(1) == 1) return 24'd0 - mag[23:0];
    if (mag > 8388607) mag = 8388607;
    return mag[23:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Bus tasks
  // ---------------------------------------------------------------------------

  // Offer one sample, idling at random first unless steady_flow is set; record the prediction on transfer.
  task automatic send_sample(input logic [23:0] sample);
    @(negedge clk_i);
    while (!steady_flow && $urandom_range(99) < 27) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= sample;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    gated_queue.push_back(step_gate(sample));
  endtask

  // Drop valid, wait until every result is back, then let the sequencer settle.
  task automatic wait_for_drain;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (gated_queue.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Two-phase register write; mirror it into the shadow registers on completion.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      ngh_pkg::RegOpenLevel:   cfg_open_level   = value[23:0];
      ngh_pkg::RegCloseLevel:  cfg_close_level  = value[23:0];
      ngh_pkg::RegFloorGain:   cfg_floor_gain   = value[23:0];
      ngh_pkg::RegUpFactor:    cfg_up_factor    = value;
      ngh_pkg::RegDownFactor:  cfg_down_factor  = value[24:0];
      ngh_pkg::RegHoldSamples: cfg_hold_samples = value[15:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset register values: thresholds on both sides of each level, full-scale
  // samples, the most negative sample and minus one.
  task automatic test_reset_levels;
    send_sample(24'd0);
    send_sample(24'd132);
    send_sample(24'd264);
    send_sample(24'd265);
    send_sample(24'd0 - 24'd265);
    send_sample(ngh_pkg::PosMax);
    send_sample(24'h800000);
    send_sample(24'hFFFFFF);
    wait_for_drain();
  endtask

  // Extreme register values: floor above unity so the output saturates,
  // largest factors, zero hold, out-of-width bits, and an unmapped address.
  task automatic test_register_extremes;
    write_reg(ngh_pkg::RegOpenLevel,   32'h0080_0000);
    write_reg(ngh_pkg::RegCloseLevel,  32'h0000_0000);
    write_reg(ngh_pkg::RegFloorGain,   32'hFFFF_FFFF);
    write_reg(ngh_pkg::RegUpFactor,    32'hFFFF_FFFF);
    write_reg(ngh_pkg::RegDownFactor,  32'hFFFF_FFFF);
    write_reg(ngh_pkg::RegHoldSamples, 32'hABCD_0000);
    write_reg(RegSpare,                32'h0000_0001);
    send_sample(ngh_pkg::PosMax); // gate still open from test_reset_levels, gain jumps to unity
    send_sample(24'h800000);      // only the most negative sample reaches the open level
    send_sample(24'd1);           // above a zero close level, gate stays open
    send_sample(24'h400000);
    wait_for_drain();
    // Close level above every sample sent: zero hold shuts the gate at once.
    write_reg(ngh_pkg::RegCloseLevel,  32'h0080_0000);
    write_reg(ngh_pkg::RegOpenLevel,   32'h0000_0000);
    write_reg(ngh_pkg::RegDownFactor,  32'h0000_0000);
    send_sample(ngh_pkg::PosMax);
    send_sample(24'hC00000);
    wait_for_drain();
  endtask

  // Zero floor with zero release drives the gain to zero, where attack
  // can no longer lift it.
  task automatic test_stuck_gain;
    write_reg(ngh_pkg::RegFloorGain,   32'd0);
    write_reg(ngh_pkg::RegUpFactor,    ngh_pkg::UpFactorRst);
    write_reg(ngh_pkg::RegOpenLevel,   32'd1000);
    write_reg(ngh_pkg::RegCloseLevel,  32'd500);
    write_reg(ngh_pkg::RegHoldSamples, 32'd2);
    send_sample(24'd0);
    send_sample(24'h100000);
    send_sample(24'd0 - 24'h100000);
    send_sample(ngh_pkg::PosMax);
    wait_for_drain();
  endtask

  // Hold countdown: open once, then quiet samples until the gate closes.
  task automatic test_hold_countdown;
    write_reg(ngh_pkg::RegFloorGain,   32'(ngh_pkg::FloorGainRst));
    write_reg(ngh_pkg::RegDownFactor,  32'(ngh_pkg::DownFactorRst));
    write_reg(ngh_pkg::RegHoldSamples, 32'd3);
    send_sample(24'h200000);
    repeat (4) send_sample(24'd7);
    wait_for_drain();
  endtask

  // Random phases: each draws a register set, then runs bursts of loud,
  // hysteresis-band and quiet samples plus raw noise.
  task automatic test_random_bursts;
    int unsigned phase;
    int unsigned sent;
    int unsigned kind;
    int unsigned run_len;
    int unsigned lo;
    int unsigned hi;
    int unsigned open_lvl;
    bit          noise;
    for (phase = 0; phase < 6; phase++) begin
      steady_flow = (phase == 2);
      open_lvl = $urandom_range(1 << 20);
      write_reg(ngh_pkg::RegOpenLevel, open_lvl);
      write_reg(ngh_pkg::RegCloseLevel,
                ($urandom_range(4) == 0) ? $urandom_range(1 << 20)
                                         : $urandom_range(open_lvl));
      write_reg(ngh_pkg::RegFloorGain,
                ($urandom_range(9) == 0) ? $urandom : $urandom_range(8388608));
      write_reg(ngh_pkg::RegUpFactor,
                ($urandom_range(9) == 0) ? $urandom : $urandom_range(8388608, 4194304));
      write_reg(ngh_pkg::RegDownFactor,
                ($urandom_range(9) == 0) ? $urandom : $urandom_range(16777216, 8388608));
      write_reg(ngh_pkg::RegHoldSamples,
                ($urandom_range(9) == 0) ? $urandom : $urandom_range(40, 1));
      sent = 0;
      while (sent < 70) begin
        kind    = $urandom_range(9);
        run_len = $urandom_range(20, 1);
        noise   = 1'b0;
        if (kind <= 3) begin
          lo = 32'(cfg_open_level);
          hi = 8388608;
        end else if (kind <= 6) begin
          lo = 0;
          hi = (cfg_close_level == 0) ? 0 : 32'(cfg_close_level) - 1;
        end else if (kind == 7) begin
          lo = 32'(cfg_close_level);
          hi = (cfg_open_level > cfg_close_level) ? 32'(cfg_open_level) - 1
                                                  : 32'(cfg_close_level);
        end else begin
          noise = 1'b1;
        end
        repeat (run_len) begin
          send_sample(noise ? 24'($urandom) : make_sample(lo, hi));
          sent++;
          // Hold off the sender mid-phase until the output side has caught up.
          if (phase == 4 && sent == 40) wait_for_drain();
        end
      end
      wait_for_drain();
    end
    steady_flow = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stall at random unless a steady stretch is running.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (steady_flow) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= 27);
    end
  end

  // Compare each result transfer with the oldest prediction.
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (gated_queue.size() == 0) begin
        $error("unexpected result transfer: tdata=%h tuser=%b", m_axis_tdata, m_axis_tuser);
        fail_count++;
      end else begin
        head_result = gated_queue.pop_front();
        if (m_axis_tdata[23:0] !== head_result.gated) begin
          $error("gated_sample: expected %h, got %h", head_result.gated, m_axis_tdata[23:0]);
          fail_count++;
        end
        if (m_axis_tuser !== head_result.open) begin
          $error("gate_open: expected %b, got %b", head_result.open, m_axis_tuser);
          fail_count++;
        end
        if (m_axis_tdata[47:24] !== head_result.gain) begin
          $error("current_gain: expected %h, got %h", head_result.gain, m_axis_tdata[47:24]);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: count cycles with no transfer on either stream.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_count <= 0;
    end else if (quiet_count >= StallLimit) begin
      $display("testbench: FAIL");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_levels();
    test_register_extremes();
    test_stuck_gain();
    test_hold_countdown();
    test_random_bursts();
    wait_for_drain();
    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/ngh_pkg.sv
rtl/ngh_mul.sv
rtl/noise_gate_hold_ramp.sv
bench/testbench.sv
